FILE: design/sorted_array_insert_assert.svh
`ifndef SORTED_ARRAY_INSERT_ASSERT_SVH
`define SORTED_ARRAY_INSERT_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define SAI_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("sorted_array_insert: same-cycle check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define SAI_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("sorted_array_insert: next-cycle check failed");

`endif

FILE: design/sai_pkg.sv
package sai_pkg;

  localparam int DATA_W       = 32;
  localparam int INDEX_W      = 4;
  localparam int POS_W        = 4;
  localparam int COUNT_W      = 5;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 16;
  localparam int READ_SLOTS   = 1 << INDEX_W;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_BAD_INDEX = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] entry;
    logic                     valid;
    logic                     ins;
  } link_t;

endpackage

FILE: design/sai_cell.sv
module sai_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               insert_en,
  input  logic signed [sai_pkg::DATA_W-1:0]  value,
  input  sai_pkg::link_t                     left,
  output sai_pkg::link_t                     right
);

  logic signed [sai_pkg::DATA_W-1:0] entry;
  logic                              valid;
  logic                              at_end;
  logic                              greater;
  logic                              ins;

  assign at_end  = left.valid && !valid;
  assign greater = valid && (entry > value);
  assign ins     = greater || at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (insert_en && ins) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (insert_en && ins) begin
      entry <= left.ins ? left.entry : value;
    end
  end

  assign right = '{entry: entry, valid: valid, ins: ins};

endmodule

FILE: design/sorted_array_insert.sv
// Sorted insertion table.
// Input words arrive on s_tvalid/s_tready with s_tdata = {index, value} (value in the low
// 32 bits) and s_tuser = mode: 0 inserts value, 1 reads the entry at index.
// Every input word yields one output word on m_tvalid/m_tready with m_tdata =
// {status, entry_count, insert_position, read_value}, read_value in the low bits.
// The table is a row of cells, one entry each; on an insert every cell compares its
// entry with the value at once and the larger entries move up one cell while the
// new value drops into the freed cell, all on the same clock edge.
// m_tvalid rises in the cycle after input accept; the block takes one word per cycle
// when the output is not stalled, and the next word sees the table as the previous left it.
// A single output register sits between the sides: when the receiver stalls, that
// word holds and s_tready stays low until it is taken.
// Reset empties the table (entry count zero) and clears m_tvalid; m_tdata is not reset.
// A full table drops inserts with status 1; a read at or beyond the count returns
// status 2.
module sorted_array_insert #(
  parameter int CAPACITY = sai_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata fields from bit 0: value[31:0], index[35:32], zero pad[39:36].
  input  logic [39:0] s_tdata,
  // s_tuser fields from bit 0: mode[0].
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata fields from bit 0: read_value[31:0], insert_position[35:32],
  // entry_count[40:36], status[42:41], zero pad[47:43].
  output logic [47:0] m_tdata
);

  localparam int CntW = $clog2(CAPACITY + 1);

  logic signed [sai_pkg::DATA_W-1:0]  value;
  logic [sai_pkg::INDEX_W-1:0]        index;
  logic                               accept;
  logic                               full;
  logic                               insert_en;
  logic [CntW-1:0]                    count;
  logic [CntW-1:0]                    count_next;
  logic [CntW+sai_pkg::COUNT_W-1:0]   count_wide;
  sai_pkg::link_t                     links [CAPACITY+1];
  logic [CAPACITY-1:0]                start;
  logic [sai_pkg::POS_W-1:0]          pos;
  logic signed [sai_pkg::DATA_W-1:0]  rd_entry [sai_pkg::READ_SLOTS];
  logic [sai_pkg::READ_SLOTS-1:0]     rd_valid;
  logic signed [sai_pkg::DATA_W-1:0]  read_value;
  logic [sai_pkg::POS_W-1:0]          insert_position;
  sai_pkg::status_t                   status;
  logic [47:0]                        m_tdata_next;

  assign value  = s_tdata[31:0];
  assign index  = s_tdata[35:32];
  assign accept = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;

  assign full      = links[CAPACITY].valid;
  assign insert_en = accept && (s_tuser == sai_pkg::MODE_INSERT) && !full;

  assign links[0] = '{entry: '0, valid: 1'b1, ins: 1'b0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sai_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .insert_en (insert_en),
      .value     (value),
      .left      (links[i]),
      .right     (links[i+1])
    );
    assign start[i] = links[i+1].ins && !links[i].ins;
  end

  for (genvar k = 0; k < sai_pkg::READ_SLOTS; k++) begin : g_read
    if (k < CAPACITY) begin : g_used
      assign rd_entry[k] = links[k+1].entry;
      assign rd_valid[k] = links[k+1].valid;
    end else begin : g_none
      assign rd_entry[k] = '0;
      assign rd_valid[k] = 1'b0;
    end
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (start[i]) begin
        pos = pos | i[sai_pkg::POS_W-1:0];
      end
    end
  end

  assign count_next = insert_en ? (count + {{(CntW-1){1'b0}}, 1'b1}) : count;
  assign count_wide = {{sai_pkg::COUNT_W{1'b0}}, count_next};

  always_comb begin
    read_value      = '0;
    insert_position = '0;
    status          = sai_pkg::STATUS_OK;
    if (s_tuser == sai_pkg::MODE_INSERT) begin
      if (full) begin
        status = sai_pkg::STATUS_FULL;
      end else begin
        insert_position = pos;
      end
    end else begin
      if (rd_valid[index]) begin
        read_value = rd_entry[index];
      end else begin
        status = sai_pkg::STATUS_BAD_INDEX;
      end
    end
  end

  assign m_tdata_next = {5'b0, status, count_wide[sai_pkg::COUNT_W-1:0], insert_position,
                         read_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= m_tdata_next;
    end
  end

endmodule

FILE: design/sai_checker.sv
`include "sorted_array_insert_assert.svh"

module sai_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  `SAI_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `SAI_ASSERT_IMPLY(a_ready_when_empty, clk, rst, !m_tvalid, s_tready)
  `SAI_ASSERT_NEXT(a_accept_gives_word, clk, rst, s_tvalid && s_tready, m_tvalid)
  `SAI_ASSERT_IMPLY(a_status_code, clk, rst, m_tvalid, m_tdata[42:41] == sai_pkg::STATUS_OK || m_tdata[42:41] == sai_pkg::STATUS_FULL || m_tdata[42:41] == sai_pkg::STATUS_BAD_INDEX)
  `SAI_ASSERT_IMPLY(a_full_zero_fields, clk, rst, m_tvalid && (m_tdata[42:41] == sai_pkg::STATUS_FULL), m_tdata[35:0] == 36'd0)

endmodule

bind sorted_array_insert sai_checker u_sai_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: verif/sorted_array_insert_checker.sv
`timescale 1ns / 1ps

module sorted_array_insert_checker
  import sai_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // s_tdata fields from bit 0: value[31:0], index[35:32], zero pad[39:36].
  input  logic [39:0] s_tdata,
  // s_tuser fields from bit 0: mode[0].
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata fields from bit 0: read_value[31:0], insert_position[35:32],
  // entry_count[40:36], status[42:41], zero pad[47:43].
  input  logic [47:0] m_tdata,
  output int          mismatches,
  output int          outstanding
);

  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         insert_position;
    logic [COUNT_W-1:0]       entry_count;
    status_t                  status;
  } outcome_t;

  logic signed [DATA_W-1:0] sorted_vals [CAPACITY];
  int unsigned              held;
  outcome_t                 pending_results [$];
  outcome_t                 wanted;
  outcome_t                 seen;
  int                       error_count;

  initial begin
    held        = 0;
    error_count = 0;
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic outcome_t insert_or_read(input logic mode,
                                              input logic signed [DATA_W-1:0] value,
                                              input logic [INDEX_W-1:0] index);
    outcome_t    r;
    int unsigned slot;
    int unsigned i;
    r.read_value      = '0;
    r.insert_position = '0;
    r.status          = STATUS_OK;
    if (mode == MODE_INSERT) begin
      if (held >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        // The new value lands after every entry less than or equal to it.
        slot = 0;
        while (slot < held && sorted_vals[slot] <= value) slot++;
        for (i = held; i > slot; i--) sorted_vals[i] = sorted_vals[i-1];
        sorted_vals[slot] = value;
        held++;
        r.insert_position = POS_W'(slot);
      end
    end else begin
      if (index < held && index < CAPACITY) r.read_value = sorted_vals[index];
      else r.status = STATUS_BAD_INDEX;
    end
    r.entry_count = COUNT_W'(held);
    return r;
  endfunction

  task automatic compare_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held = 0;
      pending_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen.read_value      = m_tdata[31:0];
        seen.insert_position = m_tdata[35:32];
        seen.entry_count     = m_tdata[40:36];
        seen.status          = status_t'(m_tdata[42:41]);
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected output word, expected none, actual %h", $time, m_tdata);
          error_count++;
        end else begin
          wanted = pending_results.pop_front();
          compare_field("read_value", wanted.read_value, seen.read_value);
          compare_field("insert_position", wanted.insert_position, seen.insert_position);
          compare_field("entry_count", wanted.entry_count, seen.entry_count);
          compare_field("status", wanted.status, seen.status);
        end
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(insert_or_read(s_tuser, s_tdata[31:0], s_tdata[35:32]));
    end
    outstanding <= pending_results.size();
    mismatches  <= error_count;
  end

endmodule

FILE: verif/tb_sorted_array_insert.sv
`timescale 1ns / 1ps

module tb_sorted_array_insert;
  import sai_pkg::*;

  localparam int RANDOM_WORDS = 1050;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic        s_tuser  = MODE_INSERT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  int          mismatches;
  int          outstanding;
  int          cycles = 0;
  int          insert_words = 0;
  int          read_words = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_array_insert DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sorted_array_insert_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding.", cycles, outstanding);
      $display("Verification failed");
      $finish;
    end
  end

  // Waits come in random lengths, broken up by runs of back-to-back words.
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 5) == 0) begin
      run_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom_range(0, 6) - 3;
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7fffffff;
          1:       return 32'sh80000000;
          2:       return -1;
          default: return 0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int run_left;
    int stall;
    run_left = 0;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait(run_left);
      repeat (stall) begin
        m_tready <= 1'b0;
        @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  int send_run_left = 0;

  task automatic send_word(input logic mode, input logic signed [DATA_W-1:0] value,
                           input logic [INDEX_W-1:0] index);
    int gap;
    gap = draw_wait(send_run_left);
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, index, value};
    s_tuser  <= mode;
    if (mode == MODE_INSERT) insert_words++;
    else read_words++;
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_word(MODE_READ, 32'sh12345678, 4'd0);
    send_word(MODE_READ, -1, 4'd15);
    send_word(MODE_INSERT, 0, 4'd0);
    send_word(MODE_INSERT, 32'sh7fffffff, 4'd15);
    send_word(MODE_INSERT, 32'sh80000000, 4'd0);
    send_word(MODE_INSERT, 0, 4'd7);
    send_word(MODE_INSERT, -1, 4'd0);
    send_word(MODE_INSERT, 1, 4'd0);
    send_word(MODE_INSERT, 32'sh55555555, 4'd10);
    send_word(MODE_INSERT, 32'shaaaaaaaa, 4'd5);
    for (int i = 0; i < 8; i++) send_word(MODE_READ, 0, 4'(i));
    send_word(MODE_READ, 0, 4'd8);
    send_word(MODE_READ, 32'sh7fffffff, 4'd15);
    wait_drained();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) wait_drained();
      if ($urandom_range(0, 7) == 0)
        send_word(MODE_INSERT, pick_value(), 4'($urandom_range(0, 15)));
      else
        send_word(MODE_READ, pick_value(), 4'($urandom_range(0, 15)));
    end
    wait_drained();
    repeat (4) @(posedge clk);

    $display("Sent %0d words: %0d inserts and %0d reads, covering empty, partial and full",
             insert_words + read_words, insert_words, read_words);
    $display("table states, equal and extreme values, and reads past the entry count.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
